>>> rtl/fl_pkg.sv
package fl_pkg;

    typedef enum logic [1:0] {
        FL_OP_RAISE     = 2'd0,
        FL_OP_CLEAR     = 2'd1,
        FL_OP_CLEAR_ALL = 2'd2,
        FL_OP_QUERY     = 2'd3
    } fl_op_t;

    typedef enum logic [1:0] {
        FL_ST_NONE    = 2'd0,
        FL_ST_CHANGED = 2'd1,
        FL_ST_REJECT  = 2'd2
    } fl_status_t;

    localparam int unsigned FL_ID_W    = 5;
    localparam int unsigned FL_CNT_W   = 5;
    localparam int unsigned FL_STAT_W  = 2;
    localparam int unsigned FL_OP_W    = 2;
    localparam int unsigned FL_IN_W    = 8;
    localparam int unsigned FL_FIXED_W = FL_STAT_W + FL_CNT_W + FL_ID_W + 4;

    typedef struct packed {
        fl_status_t           status;
        logic [FL_CNT_W-1:0]  cleared_count;
        logic [FL_ID_W-1:0]   first_fault;
        logic                 any_active;
        logic                 any_latched_active;
        logic                 id_active;
        logic                 id_latched_kind;
    } fl_result_t;

    // bits lo .. hi-1 set, within 32 bits
    function automatic logic [31:0] fl_range_mask(input int unsigned lo, input int unsigned hi);
        logic [31:0] m;
        m = '0;
        for (int i = 0; i < 32; i++) begin
            m[i] = (i >= lo) && (i < hi);
        end
        return m;
    endfunction

    // index of the lowest set bit, zero when none
    function automatic logic [FL_ID_W-1:0] fl_lowest(input logic [31:0] x);
        logic [31:0]        iso;
        logic [FL_ID_W-1:0] r;
        iso = x & (~x + 32'd1);
        r   = '0;
        for (int i = 0; i < 32; i++) begin
            if (iso[i]) begin
                r = r | FL_ID_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [5:0] fl_popcount(input logic [31:0] x);
        logic [2:0] nib [8];
        logic [5:0] s;
        for (int n = 0; n < 8; n++) begin
            nib[n] = 3'(x[4*n]) + 3'(x[4*n+1]) + 3'(x[4*n+2]) + 3'(x[4*n+3]);
        end
        s = '0;
        for (int n = 0; n < 8; n++) begin
            s = s + 6'(nib[n]);
        end
        return s;
    endfunction

endpackage

>>> rtl/fault_latch_register.sv
// channel  | dir | tdata fields (lsb first)
// s_axis   | in  | operation[1:0], fault_id[6:2]
// m_axis   | out | status, cleared_count, active_mask, first_fault, any_active,
//          |     | any_latched_active, id_active, id_latched_kind
// one item per cycle sustained while the receiver keeps m_tready high
// input register, then update logic, then result register
// reset clears the flags, the first fault and both valid bits
// the input register advances only when the result register is free or taken
module fault_latch_register import fl_pkg::*; #(
    parameter int unsigned NUM_FAULTS          = 19,
    parameter int unsigned FIRST_SELF_CLEARING = 14,
    parameter int unsigned UNCLEARABLE_ID      = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // operation[1:0], fault_id[6:2], zero[7]
    input  logic [FL_IN_W-1:0]   s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status, cleared_count, active_mask, first_fault, any_active,
    // any_latched_active, id_active, id_latched_kind, zero pad
    output logic [((FL_FIXED_W + NUM_FAULTS + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int unsigned OUT_W = ((FL_FIXED_W + NUM_FAULTS + 7) / 8) * 8;
    localparam int unsigned PAD_W = OUT_W - FL_FIXED_W - NUM_FAULTS;

    logic                   in_valid_reg;
    fl_op_t                 op_reg;
    logic [FL_ID_W-1:0]     id_reg;
    logic [NUM_FAULTS-1:0]  flags_reg;
    logic [NUM_FAULTS-1:0]  flags_next;
    logic [FL_ID_W-1:0]     first_reg;
    logic [FL_ID_W-1:0]     first_next;
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_data_reg;
    logic [OUT_W-1:0]       out_data_next;
    fl_result_t             result;
    logic                   advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    fl_core #(
        .NUM_FAULTS          (NUM_FAULTS),
        .FIRST_SELF_CLEARING (FIRST_SELF_CLEARING),
        .UNCLEARABLE_ID      (UNCLEARABLE_ID)
    ) u_core (
        .operation  (op_reg),
        .fault_id   (id_reg),
        .flags      (flags_reg),
        .first_id   (first_reg),
        .flags_next (flags_next),
        .first_next (first_next),
        .result     (result)
    );

    assign out_data_next = {
        PAD_W'(0),
        result.id_latched_kind,
        result.id_active,
        result.any_latched_active,
        result.any_active,
        result.first_fault,
        flags_next,
        result.cleared_count,
        result.status
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            first_reg     <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
                first_reg     <= first_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            op_reg <= fl_op_t'(s_tdata[FL_OP_W-1:0]);
            id_reg <= s_tdata[FL_OP_W +: FL_ID_W];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

>>> rtl/fl_core.sv
module fl_core import fl_pkg::*; #(
    parameter int unsigned NUM_FAULTS          = 19,
    parameter int unsigned FIRST_SELF_CLEARING = 14,
    parameter int unsigned UNCLEARABLE_ID      = 1
) (
    input  fl_op_t                  operation,
    input  logic [FL_ID_W-1:0]      fault_id,
    input  logic [NUM_FAULTS-1:0]   flags,
    input  logic [FL_ID_W-1:0]      first_id,
    output logic [NUM_FAULTS-1:0]   flags_next,
    output logic [FL_ID_W-1:0]      first_next,
    output fl_result_t              result
);

    localparam logic [31:0] VALID_32   = fl_range_mask(1, NUM_FAULTS);
    localparam logic [31:0] LATCHED_32 = fl_range_mask(1, FIRST_SELF_CLEARING) & VALID_32;
    localparam logic [31:0] UNCLR_32   = fl_range_mask(UNCLEARABLE_ID, UNCLEARABLE_ID + 1);
    localparam logic [NUM_FAULTS-1:0] LATCHED_MASK = LATCHED_32[NUM_FAULTS-1:0];
    localparam logic [NUM_FAULTS-1:0] CLR_ALL_MASK =
        LATCHED_32[NUM_FAULTS-1:0] & ~UNCLR_32[NUM_FAULTS-1:0];

    logic                    id_ok;
    logic [NUM_FAULTS-1:0]   id_bit;
    logic [NUM_FAULTS-1:0]   after_one;
    logic [NUM_FAULTS-1:0]   after_all;
    logic [NUM_FAULTS-1:0]   removed;
    logic [FL_ID_W-1:0]      low_one;
    logic [FL_ID_W-1:0]      low_all;
    logic [FL_CNT_W-1:0]     rm_count;
    fl_status_t              status;
    logic [FL_CNT_W-1:0]     count;

    assign id_ok     = (fault_id != '0) && ({1'b0, fault_id} < 6'(NUM_FAULTS));
    assign id_bit    = id_ok ? (NUM_FAULTS'(1) << fault_id) : '0;
    assign after_one = flags & ~id_bit;
    assign removed   = flags & CLR_ALL_MASK;
    assign after_all = flags & ~removed;
    assign low_one   = fl_lowest(32'(after_one));
    assign low_all   = fl_lowest(32'(after_all));
    assign rm_count  = FL_CNT_W'(fl_popcount(32'(removed)));

    always_comb begin
        flags_next = flags;
        first_next = first_id;
        status     = FL_ST_NONE;
        count      = '0;
        unique case (operation)
            FL_OP_RAISE: begin
                if (!id_ok) begin
                    status = FL_ST_REJECT;
                end else if ((flags & id_bit) == '0) begin
                    flags_next = flags | id_bit;
                    if (first_id == '0) begin
                        first_next = fault_id;
                    end
                    status = FL_ST_CHANGED;
                end
            end
            FL_OP_CLEAR: begin
                if (!id_ok || ({1'b0, fault_id} == 6'(UNCLEARABLE_ID))) begin
                    status = FL_ST_REJECT;
                end else if ((flags & id_bit) != '0) begin
                    flags_next = after_one;
                    if (first_id == fault_id) begin
                        first_next = low_one;
                    end
                    status = FL_ST_CHANGED;
                end
            end
            FL_OP_CLEAR_ALL: begin
                flags_next = after_all;
                first_next = low_all;
                count      = rm_count;
                if ((rm_count != '0) || (low_all != first_id)) begin
                    status = FL_ST_CHANGED;
                end
            end
            FL_OP_QUERY: begin
                status = FL_ST_NONE;
            end
        endcase
    end

    always_comb begin
        result.status             = status;
        result.cleared_count      = count;
        result.first_fault        = first_next;
        result.any_active         = |flags_next;
        result.any_latched_active = |(flags_next & LATCHED_MASK);
        result.id_active          = |(flags_next & id_bit);
        result.id_latched_kind    = id_ok && ({1'b0, fault_id} < 6'(FIRST_SELF_CLEARING));
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import fl_pkg::*;

    localparam int unsigned NUM_FAULTS          = 19;
    localparam int unsigned FIRST_SELF_CLEARING = 14;
    localparam int unsigned UNCLEARABLE_ID      = 1;
    localparam int unsigned RES_W       = ((FL_FIXED_W + NUM_FAULTS + 7) / 8) * 8;
    localparam int unsigned CYCLE_LIMIT = 50000;
    localparam int unsigned HOLD_CYCLES = 120;

    typedef struct packed {
        fl_op_t                op;
        logic [FL_ID_W-1:0]    fault_id;
    } fault_cmd_t;

    typedef struct packed {
        fl_status_t            status;
        logic [FL_CNT_W-1:0]   cleared_count;
        logic [NUM_FAULTS-1:0] active_mask;
        logic [FL_ID_W-1:0]    first_fault;
        logic                  any_active;
        logic                  any_latched;
        logic                  id_active;
        logic                  id_latched;
    } fault_report_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [FL_IN_W-1:0]  s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [RES_W-1:0]    m_tdata;

    fault_cmd_t          pending_items[$];
    fault_report_t       expected_reports[$];
    logic [NUM_FAULTS-1:0] fault_flags = '0;
    logic [FL_ID_W-1:0]  first_fault_id = '0;
    int                  accepted_cnt = 0;
    int                  total_items = 0;
    int                  error_cnt = 0;
    int                  cycle_cnt = 0;
    logic                hold_off = 1'b0;

    fault_latch_register #(
        .NUM_FAULTS          (NUM_FAULTS),
        .FIRST_SELF_CLEARING (FIRST_SELF_CLEARING),
        .UNCLEARABLE_ID      (UNCLEARABLE_ID)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic logic [FL_ID_W-1:0] lowest_active_fault();
        logic [FL_ID_W-1:0] low;
        low = '0;
        for (int i = NUM_FAULTS - 1; i >= 1; i--) begin
            if (fault_flags[i]) begin
                low = FL_ID_W'(i);
            end
        end
        return low;
    endfunction

    // applies one command to the fault register copy and returns the report
    function automatic fault_report_t predict_fault_update(fl_op_t op, logic [FL_ID_W-1:0] id);
        fault_report_t         r;
        logic                  ok;
        logic [NUM_FAULTS-1:0] id_bit;
        logic [NUM_FAULTS-1:0] latched;
        logic [NUM_FAULTS-1:0] removed;
        logic [FL_ID_W-1:0]    old_first;
        int                    count;
        r       = '0;
        ok      = (id != 0) && (id < NUM_FAULTS);
        id_bit  = ok ? (NUM_FAULTS'(1) << id) : '0;
        latched = '0;
        for (int i = 1; i < NUM_FAULTS; i++) begin
            latched[i] = (i < FIRST_SELF_CLEARING);
        end
        r.status = FL_ST_NONE;
        case (op)
            FL_OP_RAISE: begin
                if (!ok) begin
                    r.status = FL_ST_REJECT;
                end else if ((fault_flags & id_bit) == '0) begin
                    fault_flags = fault_flags | id_bit;
                    if (first_fault_id == 0) begin
                        first_fault_id = id;
                    end
                    r.status = FL_ST_CHANGED;
                end
            end
            FL_OP_CLEAR: begin
                if (!ok || id == UNCLEARABLE_ID) begin
                    r.status = FL_ST_REJECT;
                end else if ((fault_flags & id_bit) != '0) begin
                    fault_flags = fault_flags & ~id_bit;
                    if (first_fault_id == id) begin
                        first_fault_id = lowest_active_fault();
                    end
                    r.status = FL_ST_CHANGED;
                end
            end
            FL_OP_CLEAR_ALL: begin
                removed = fault_flags & latched;
                if (UNCLEARABLE_ID < NUM_FAULTS) begin
                    removed[UNCLEARABLE_ID] = 1'b0;
                end
                count = 0;
                for (int i = 0; i < NUM_FAULTS; i++) begin
                    count += removed[i];
                end
                old_first      = first_fault_id;
                fault_flags    = fault_flags & ~removed;
                first_fault_id = lowest_active_fault();
                r.cleared_count = FL_CNT_W'(count);
                if (count != 0 || first_fault_id != old_first) begin
                    r.status = FL_ST_CHANGED;
                end
            end
            default: begin
            end
        endcase
        r.active_mask = fault_flags;
        r.first_fault = first_fault_id;
        r.any_active  = |fault_flags;
        r.any_latched = |(fault_flags & latched);
        r.id_active   = ok && ((fault_flags & id_bit) != '0);
        r.id_latched  = ok && (id < FIRST_SELF_CLEARING);
        return r;
    endfunction

    function automatic logic idle_roll();
        if (accepted_cnt >= 250 && accepted_cnt < 380) begin
            return 1'b0;
        end
        return $urandom_range(99) < 9;
    endfunction

    task automatic add_cmd(fl_op_t op, int unsigned id);
        fault_cmd_t c;
        c.op       = op;
        c.fault_id = FL_ID_W'(id);
        pending_items.push_back(c);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_cnt, what, got, want);
        error_cnt++;
    endtask

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge aclk) begin : drive_items
        fault_cmd_t cmd;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_reports.push_back(
                    predict_fault_update(fl_op_t'(s_tdata[1:0]), s_tdata[6:2]));
                accepted_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && !idle_roll()) begin
                    cmd = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, cmd.fault_id, cmd.op};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_off && !idle_roll();
        end
    end

    // long receiver stall so the pipeline backs up into the input
    initial begin
        wait (aresetn);
        wait (accepted_cnt >= 60);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    always @(posedge aclk) begin : check_reports
        fault_report_t got;
        fault_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status        = fl_status_t'(m_tdata[1:0]);
            got.cleared_count = m_tdata[6:2];
            got.active_mask   = m_tdata[25:7];
            got.first_fault   = m_tdata[30:26];
            got.any_active    = m_tdata[31];
            got.any_latched   = m_tdata[32];
            got.id_active     = m_tdata[33];
            got.id_latched    = m_tdata[34];
            if (expected_reports.size() == 0) begin
                report_mismatch("unexpected item", 32'(m_tdata), '0);
            end else begin
                want = expected_reports.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.cleared_count != want.cleared_count)
                    report_mismatch("cleared_count", 32'(got.cleared_count),
                                    32'(want.cleared_count));
                if (got.active_mask != want.active_mask)
                    report_mismatch("active_mask", 32'(got.active_mask),
                                    32'(want.active_mask));
                if (got.first_fault != want.first_fault)
                    report_mismatch("first_fault", 32'(got.first_fault),
                                    32'(want.first_fault));
                if (got.any_active != want.any_active)
                    report_mismatch("any_active", 32'(got.any_active), 32'(want.any_active));
                if (got.any_latched != want.any_latched)
                    report_mismatch("any_latched_active", 32'(got.any_latched),
                                    32'(want.any_latched));
                if (got.id_active != want.id_active)
                    report_mismatch("id_active", 32'(got.id_active), 32'(want.id_active));
                if (got.id_latched != want.id_latched)
                    report_mismatch("id_latched_kind", 32'(got.id_latched),
                                    32'(want.id_latched));
            end
        end
    end

    initial begin
        int unsigned pick;
        int unsigned id;
        fl_op_t      op;

        // directed
        add_cmd(FL_OP_QUERY, 0);
        add_cmd(FL_OP_RAISE, 0);
        add_cmd(FL_OP_RAISE, 31);
        add_cmd(FL_OP_RAISE, NUM_FAULTS);
        add_cmd(FL_OP_CLEAR, NUM_FAULTS);
        add_cmd(FL_OP_RAISE, NUM_FAULTS - 1);
        add_cmd(FL_OP_CLEAR, NUM_FAULTS - 1);
        add_cmd(FL_OP_RAISE, FIRST_SELF_CLEARING);
        add_cmd(FL_OP_RAISE, UNCLEARABLE_ID);
        add_cmd(FL_OP_CLEAR_ALL, 0);
        add_cmd(FL_OP_CLEAR_ALL, 31);
        add_cmd(FL_OP_CLEAR, UNCLEARABLE_ID);
        add_cmd(FL_OP_CLEAR, 0);
        add_cmd(FL_OP_RAISE, FIRST_SELF_CLEARING - 1);
        add_cmd(FL_OP_RAISE, FIRST_SELF_CLEARING - 1);
        add_cmd(FL_OP_RAISE, 2);
        add_cmd(FL_OP_CLEAR, 7);
        add_cmd(FL_OP_RAISE, NUM_FAULTS - 1);
        add_cmd(FL_OP_QUERY, NUM_FAULTS - 1);
        add_cmd(FL_OP_QUERY, 31);
        add_cmd(FL_OP_CLEAR_ALL, 5);
        add_cmd(FL_OP_CLEAR, FIRST_SELF_CLEARING);
        add_cmd(FL_OP_QUERY, UNCLEARABLE_ID);

        // random commands, with bursts of latched raises followed by clear-all
        for (int round = 0; round < 12; round++) begin
            for (int k = 0; k < 35; k++) begin
                pick = $urandom_range(99);
                if (pick < 40)      op = FL_OP_RAISE;
                else if (pick < 70) op = FL_OP_CLEAR;
                else if (pick < 78) op = FL_OP_CLEAR_ALL;
                else                op = FL_OP_QUERY;
                if ($urandom_range(99) < 88)
                    id = $urandom_range(NUM_FAULTS - 1, 1);
                else if ($urandom_range(3) == 0)
                    id = 0;
                else
                    id = $urandom_range(31, NUM_FAULTS);
                add_cmd(op, id);
            end
            repeat ($urandom_range(13, 4))
                add_cmd(FL_OP_RAISE, $urandom_range(FIRST_SELF_CLEARING - 1, 1));
            add_cmd(FL_OP_CLEAR_ALL, $urandom_range(31));
        end
        total_items = pending_items.size();

        wait (aresetn);
        while (!(accepted_cnt == total_items && expected_reports.size() == 0))
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/fl_pkg.sv
rtl/fl_core.sv
rtl/fault_latch_register.sv
verif/testbench.sv
